FILE: design/pcvg_pkg.sv
package pcvg_pkg;

  // Angle and coordinate formats
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int COORD_FRAC_BITS = 14;
  localparam int QUARTER_TURN    = 90 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
  localparam int ROM_ADDR_W      = $clog2(QUARTER_TURN + 1);

  localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

  // Rounded-up reciprocals of the series divisors 2k(2k+1); the shift keeps the
  // quotient exact for dividends below 2^32
  localparam int              RECIP_SHIFT = 40;
  localparam longint unsigned RECIP_6     = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
  localparam longint unsigned RECIP_20    = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
  localparam longint unsigned RECIP_42    = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
  localparam longint unsigned RECIP_72    = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
  localparam longint unsigned RECIP_110   = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
  localparam longint unsigned RECIP_156   = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;

  // Field widths of the request and vertex
  localparam int YAW_W   = 13;
  localparam int PITCH_W = 11;
  localparam int COORD_W = 16;
  localparam int SHADE_W = 32;
  localparam int U_W     = 18;
  localparam int V_W     = 17;

  // Geometry carries 31 fraction bits before rounding
  localparam int GEO_W       = 35;
  localparam int ROUND_SHIFT = 31 - COORD_FRAC_BITS;

  localparam int VERTS_PER_CUBE = 12;
  localparam logic [3:0] LAST_VERTEX_IDX = 4'(VERTS_PER_CUBE - 1);

  localparam logic [1:0] FACE_TOP   = 2'd0;
  localparam logic [1:0] FACE_LEFT  = 2'd1;
  localparam logic [1:0] FACE_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    CFG_TILE_COLUMN,
    CFG_TILE_ROW,
    CFG_TILE_SIZE,
    CFG_TOP_SHADE,
    CFG_FRONT_SHADE,
    CFG_LEFT_SHADE,
    CFG_BACK_SHADE,
    CFG_RIGHT_SHADE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    YAW_Q0,
    YAW_Q1,
    YAW_Q2,
    YAW_Q3
  } yaw_quad_t;

  typedef logic        [15:0]      sine_mag_t;
  typedef logic signed [17:0]      side_t;
  typedef logic signed [GEO_W-1:0] geo_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef sine_mag_t sine_rom_t [QUARTER_TURN + 1];

  localparam geo_t ROUND_BIAS = geo_t'(longint'(1) << (ROUND_SHIFT - 1));
  localparam geo_t COORD_HI   = geo_t'(32767);
  localparam geo_t COORD_LO   = geo_t'(-32768);

  typedef struct packed {
    logic [YAW_W-1:0]   yaw_angle;
    logic [PITCH_W-1:0] pitch_angle;
  } angle_req_t;

  typedef struct packed {
    coord_t             vertex_x;
    coord_t             vertex_y;
    logic [SHADE_W-1:0] vertex_shade;
    logic [U_W-1:0]     tex_u;
    logic [V_W-1:0]     tex_v;
    logic [1:0]         face_index;
    logic               last_vertex;
  } vertex_t;

  // Geometry terms before the final shift and clamp; only x and y terms biased
  typedef struct packed {
    geo_t x_a;
    geo_t x_nb;
    geo_t x_na;
    geo_t x_b;
    geo_t x_mid;
    geo_t x_left;
    geo_t x_right;
    geo_t y_t0;
    geo_t y_t1;
    geo_t y_t2;
    geo_t y_t3;
    geo_t y_mid;
    geo_t tu;
    geo_t tu_m;
    geo_t tl;
    geo_t tl_m;
    geo_t cp16;
  } raw_geo_t;

  // Every distinct coordinate of one cube
  typedef struct packed {
    coord_t x_a;
    coord_t x_nb;
    coord_t x_na;
    coord_t x_b;
    coord_t x_mid;
    coord_t x_left;
    coord_t x_right;
    coord_t y_t0;
    coord_t y_t1;
    coord_t y_t2;
    coord_t y_t3;
    coord_t y_mid;
    coord_t y_mid_lo;
    coord_t y_left_top;
    coord_t y_left_bot;
    coord_t y_right_top;
    coord_t y_right_bot;
  } cube_coord_t;

  // Taylor series of sine up to x^13, evaluated at elaboration only
  function automatic sine_mag_t quarter_sine(input int unsigned ang);
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned m;
    longint unsigned r;
    longint          sum;
    logic [127:0]    prod;
    sine_mag_t       res;
    a = ang;
    if (a > longint'(QUARTER_TURN)) a = longint'(QUARTER_TURN);
    x  = (a * RAD_PER_DEG_Q30 + ((64'd1 << ANGLE_FRAC_BITS) >> 1)) >> ANGLE_FRAC_BITS;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      case (k)
        1:       m = RECIP_6;
        2:       m = RECIP_20;
        3:       m = RECIP_42;
        4:       m = RECIP_72;
        5:       m = RECIP_110;
        default: m = RECIP_156;
      endcase
      prod = 128'((term * x2) >> 30) * 128'(m);
      term = 64'(prod >> RECIP_SHIFT);
      if ((k % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum <= 0) begin
      res = '0;
    end else begin
      r = (longint'(sum) + (64'd1 << 14)) >> 15;
      if (r > 64'd32768) r = 64'd32768;
      res = r[15:0];
    end
    return res;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i <= QUARTER_TURN; i++) rom[i] = quarter_sine(i);
    return rom;
  endfunction

  // Drop fraction bits (bias already added) and clamp to the coordinate range
  function automatic coord_t round_coord(input geo_t v);
    geo_t   q;
    coord_t r;
    q = v >>> ROUND_SHIFT;
    if (q > COORD_HI)      r = coord_t'(COORD_HI[COORD_W-1:0]);
    else if (q < COORD_LO) r = coord_t'(COORD_LO[COORD_W-1:0]);
    else                   r = coord_t'(q[COORD_W-1:0]);
    return r;
  endfunction

endpackage

FILE: design/projected_cube_vertex_generator_core.sv
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  ----------------------------------------------
// in       in   in_valid/in_stall  angle_req_t: yaw_angle, pitch_angle
// out      out  out_valid/out_stall vertex_t: x, y, shade, u, v, face, last flag
// cfg      in   cfg_wr_en          cfg_index (cfg_reg_t), cfg_data (32 bits)
//
// Each request yields twelve vertices on consecutive cycles when out is not
// stalled; the result port sets the sustained rate, as the last stage holds a
// cube until all twelve of its vertices have left. A request passes a 7-stage
// pipeline (reduce, address, sine ROM read, sign, multiply, combine,
// round/clamp) and the output register. Requests are taken while earlier ones
// are still in flight; each stage holds under stall and bubbles collapse. rst
// is synchronous: it empties the pipeline and loads the register reset values.
module projected_cube_vertex_generator_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pcvg_pkg::angle_req_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcvg_pkg::vertex_t     out_data,
  input  logic                  cfg_wr_en,
  input  pcvg_pkg::cfg_reg_t    cfg_index,
  input  logic [31:0]           cfg_data
);
  import pcvg_pkg::*;

  localparam int NUM_STAGES = 7;
  localparam int PROD_W     = 36;

  localparam sine_rom_t SINE_YAW   = build_sine_rom();
  localparam sine_rom_t SINE_PITCH = build_sine_rom();

  // Configuration registers
  logic [7:0]         tile_column;
  logic [7:0]         tile_row;
  logic [8:0]         tile_size;
  logic [SHADE_W-1:0] top_shade;
  logic [SHADE_W-1:0] front_shade;
  logic [SHADE_W-1:0] left_shade;
  logic [SHADE_W-1:0] back_shade;
  logic [SHADE_W-1:0] right_shade;

  // Texture coordinates derived from configuration
  logic [16:0]    col_size;
  logic [16:0]    row_size;
  logic [U_W-1:0] u_base;
  logic [U_W-1:0] u_one;
  logic [U_W-1:0] u_two;
  logic [V_W-1:0] v_base;
  logic [V_W-1:0] v_one;

  // Pipeline control
  logic [NUM_STAGES:1] pipe_valid;
  logic [NUM_STAGES:1] stage_en;
  logic [3:0]          vidx;
  logic                out_load;
  logic                emit;
  logic                cube_done;

  // Stage 1
  logic [YAW_W-1:0]      yaw1;
  logic [ROM_ADDR_W-1:0] pitch1;
  logic [YAW_W-1:0]      yaw_red;
  logic [ROM_ADDR_W-1:0] pitch_sat;
  // Stage 2
  yaw_quad_t             quad2;
  logic [ROM_ADDR_W-1:0] addr_rem2;
  logic [ROM_ADDR_W-1:0] addr_comp2;
  logic [ROM_ADDR_W-1:0] addr_pit2;
  logic [ROM_ADDR_W-1:0] addr_pitc2;
  yaw_quad_t             quad_next;
  logic [ROM_ADDR_W-1:0] rem_next;
  // Stage 3
  yaw_quad_t quad3;
  sine_mag_t tr3;
  sine_mag_t tc3;
  sine_mag_t sp3;
  sine_mag_t cp3;
  // Stage 4
  yaw_quad_t quad4;
  side_t     a4;
  side_t     b4;
  side_t     sum4;
  side_t     nd4;
  sine_mag_t tr4;
  sine_mag_t tc4;
  sine_mag_t sp4;
  sine_mag_t cp4;
  side_t     a_next;
  side_t     b_next;
  side_t     tr_s;
  side_t     tc_s;
  side_t     diff_s;
  side_t     sum_s;
  // Stage 5
  yaw_quad_t                quad5;
  geo_t                     pa5;
  geo_t                     pb5;
  geo_t                     pm5;
  logic [31:0]              pc5;
  logic [31:0]              ps5;
  side_t                    a5;
  side_t                    b5;
  side_t                    sum5;
  side_t                    nd5;
  sine_mag_t                cp5;
  side_t                    sp_s;
  logic signed [PROD_W-1:0] pa_full;
  logic signed [PROD_W-1:0] pb_full;
  logic signed [PROD_W-1:0] pm_full;
  logic [31:0]              pc_full;
  logic [31:0]              ps_full;
  // Stage 6
  yaw_quad_t quad6;
  raw_geo_t  raw6;
  raw_geo_t  raw_next;
  geo_t      h_bias;
  // Stage 7
  yaw_quad_t   quad7;
  cube_coord_t geo7;
  cube_coord_t geo_next;

  vertex_t            vert_next;
  logic [SHADE_W-1:0] shade_left;
  logic [SHADE_W-1:0] shade_right;

  // ---------------------------------------------------------------------------
  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column <= '0;
      tile_row    <= '0;
      tile_size   <= 9'd16;
      top_shade   <= '1;
      front_shade <= '1;
      left_shade  <= '1;
      back_shade  <= '1;
      right_shade <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TILE_COLUMN: tile_column <= cfg_data[7:0];
        CFG_TILE_ROW:    tile_row    <= cfg_data[7:0];
        CFG_TILE_SIZE:   tile_size   <= cfg_data[8:0];
        CFG_TOP_SHADE:   top_shade   <= cfg_data;
        CFG_FRONT_SHADE: front_shade <= cfg_data;
        CFG_LEFT_SHADE:  left_shade  <= cfg_data;
        CFG_BACK_SHADE:  back_shade  <= cfg_data;
        CFG_RIGHT_SHADE: right_shade <= cfg_data;
      endcase
    end
  end

  // Multiply, then add the tile offsets; settles before a later request reaches out
  always_ff @(posedge clk) begin
    col_size <= tile_column * tile_size;
    row_size <= tile_row * tile_size;
    u_base   <= {col_size, 1'b0};
    u_one    <= {col_size, 1'b0} + U_W'(tile_size);
    u_two    <= {col_size, 1'b0} + U_W'({tile_size, 1'b0});
    v_base   <= row_size;
    v_one    <= row_size + V_W'(tile_size);
  end

  // ---------------------------------------------------------------------------
  // Handshake
  always_comb begin
    out_load  = !out_valid || !out_stall;
    emit      = out_load && pipe_valid[NUM_STAGES];
    cube_done = emit && (vidx == LAST_VERTEX_IDX);
    stage_en[NUM_STAGES] = !pipe_valid[NUM_STAGES] || cube_done;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      stage_en[k] = !pipe_valid[k] || stage_en[k+1];
    end
  end

  assign in_stall = !stage_en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
      vidx       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (stage_en[1]) pipe_valid[1] <= in_valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (stage_en[k]) pipe_valid[k] <= pipe_valid[k-1];
      end
      if (out_load) out_valid <= pipe_valid[NUM_STAGES];
      if (emit) vidx <= (vidx == LAST_VERTEX_IDX) ? '0 : vidx + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: wrap yaw, clamp pitch
  always_comb begin
    if (in_data.yaw_angle >= YAW_W'(FULL_TURN)) begin
      yaw_red = in_data.yaw_angle - YAW_W'(FULL_TURN);
    end else begin
      yaw_red = in_data.yaw_angle;
    end
    if (in_data.pitch_angle > PITCH_W'(QUARTER_TURN)) begin
      pitch_sat = ROM_ADDR_W'(QUARTER_TURN);
    end else begin
      pitch_sat = ROM_ADDR_W'(in_data.pitch_angle);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      yaw1   <= yaw_red;
      pitch1 <= pitch_sat;
    end
  end

  // Stage 2: quadrant and table addresses
  always_comb begin
    priority if (yaw1 >= YAW_W'(3 * QUARTER_TURN)) begin
      quad_next = YAW_Q3;
      rem_next  = ROM_ADDR_W'(yaw1 - YAW_W'(3 * QUARTER_TURN));
    end else if (yaw1 >= YAW_W'(2 * QUARTER_TURN)) begin
      quad_next = YAW_Q2;
      rem_next  = ROM_ADDR_W'(yaw1 - YAW_W'(2 * QUARTER_TURN));
    end else if (yaw1 >= YAW_W'(QUARTER_TURN)) begin
      quad_next = YAW_Q1;
      rem_next  = ROM_ADDR_W'(yaw1 - YAW_W'(QUARTER_TURN));
    end else begin
      quad_next = YAW_Q0;
      rem_next  = ROM_ADDR_W'(yaw1);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      quad2      <= quad_next;
      addr_rem2  <= rem_next;
      addr_comp2 <= ROM_ADDR_W'(QUARTER_TURN) - rem_next;
      addr_pit2  <= pitch1;
      addr_pitc2 <= ROM_ADDR_W'(QUARTER_TURN) - pitch1;
    end
  end

  // Stage 3: sine table reads, two ports on each copy
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      tr3 <= SINE_YAW[addr_rem2];
      tc3 <= SINE_YAW[addr_comp2];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      sp3   <= SINE_PITCH[addr_pit2];
      cp3   <= SINE_PITCH[addr_pitc2];
      quad3 <= quad2;
    end
  end

  // Stage 4: apply quadrant signs, A = cos - sin, B = cos + sin
  always_comb begin
    tr_s   = side_t'(tr3);
    tc_s   = side_t'(tc3);
    diff_s = tc_s - tr_s;
    sum_s  = tc_s + tr_s;
    unique case (quad3)
      YAW_Q0: begin a_next = diff_s;  b_next = sum_s;   end
      YAW_Q1: begin a_next = -sum_s;  b_next = diff_s;  end
      YAW_Q2: begin a_next = -diff_s; b_next = -sum_s;  end
      YAW_Q3: begin a_next = sum_s;   b_next = -diff_s; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      quad4 <= quad3;
      a4    <= a_next;
      b4    <= b_next;
      sum4  <= sum_s;
      nd4   <= -diff_s;
      tr4   <= tr3;
      tc4   <= tc3;
      sp4   <= sp3;
      cp4   <= cp3;
    end
  end

  // Stage 5: products with sin(pitch)
  assign sp_s    = side_t'(sp4);
  assign pa_full = a4 * sp_s;
  assign pb_full = b4 * sp_s;
  assign pm_full = sum4 * sp_s;
  assign pc_full = tc4 * sp4;
  assign ps_full = tr4 * sp4;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      quad5 <= quad4;
      pa5   <= GEO_W'(pa_full);
      pb5   <= GEO_W'(pb_full);
      pm5   <= GEO_W'(pm_full);
      pc5   <= pc_full;
      ps5   <= ps_full;
      a5    <= a4;
      b5    <= b4;
      sum5  <= sum4;
      nd5   <= nd4;
      cp5   <= cp4;
    end
  end

  // Stage 6: combine terms; rounding bias folded into every coordinate
  always_comb begin
    h_bias = (geo_t'(cp5) <<< 15) + ROUND_BIAS;
    raw_next.x_a     = (geo_t'(a5) <<< 15) + ROUND_BIAS;
    raw_next.x_nb    = ROUND_BIAS - (geo_t'(b5) <<< 15);
    raw_next.x_na    = ROUND_BIAS - (geo_t'(a5) <<< 15);
    raw_next.x_b     = (geo_t'(b5) <<< 15) + ROUND_BIAS;
    raw_next.x_mid   = (geo_t'(nd5) <<< 15) + ROUND_BIAS;
    raw_next.x_left  = ROUND_BIAS - (geo_t'(sum5) <<< 15);
    raw_next.x_right = (geo_t'(sum5) <<< 15) + ROUND_BIAS;
    raw_next.y_t0    = pb5 + h_bias;
    raw_next.y_t1    = pa5 + h_bias;
    raw_next.y_t2    = h_bias - pb5;
    raw_next.y_t3    = h_bias - pa5;
    raw_next.y_mid   = h_bias - pm5;
    raw_next.cp16    = geo_t'(cp5) <<< 16;
    raw_next.tu      = geo_t'(pc5) <<< 1;
    raw_next.tu_m    = (geo_t'(pc5) <<< 1) - (geo_t'(cp5) <<< 16);
    raw_next.tl      = geo_t'(ps5) <<< 1;
    raw_next.tl_m    = (geo_t'(ps5) <<< 1) - (geo_t'(cp5) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      quad6 <= quad5;
      raw6  <= raw_next;
    end
  end

  // Stage 7: side heights, then round and clamp every coordinate
  always_comb begin
    geo_next.x_a         = round_coord(raw6.x_a);
    geo_next.x_nb        = round_coord(raw6.x_nb);
    geo_next.x_na        = round_coord(raw6.x_na);
    geo_next.x_b         = round_coord(raw6.x_b);
    geo_next.x_mid       = round_coord(raw6.x_mid);
    geo_next.x_left      = round_coord(raw6.x_left);
    geo_next.x_right     = round_coord(raw6.x_right);
    geo_next.y_t0        = round_coord(raw6.y_t0);
    geo_next.y_t1        = round_coord(raw6.y_t1);
    geo_next.y_t2        = round_coord(raw6.y_t2);
    geo_next.y_t3        = round_coord(raw6.y_t3);
    geo_next.y_mid       = round_coord(raw6.y_mid);
    geo_next.y_mid_lo    = round_coord(raw6.y_mid - raw6.cp16);
    geo_next.y_left_top  = round_coord(raw6.y_mid + raw6.tu);
    geo_next.y_left_bot  = round_coord(raw6.y_mid + raw6.tu_m);
    geo_next.y_right_top = round_coord(raw6.y_mid + raw6.tl);
    geo_next.y_right_bot = round_coord(raw6.y_mid + raw6.tl_m);
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      quad7 <= quad6;
      geo7  <= geo_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex select
  always_comb begin
    unique case (quad7)
      YAW_Q0: begin shade_left = right_shade; shade_right = front_shade; end
      YAW_Q1: begin shade_left = back_shade;  shade_right = right_shade; end
      YAW_Q2: begin shade_left = left_shade;  shade_right = back_shade;  end
      YAW_Q3: begin shade_left = front_shade; shade_right = left_shade;  end
    endcase

    vert_next.face_index  = vidx[3:2];
    vert_next.last_vertex = (vidx == LAST_VERTEX_IDX);
    unique case (vidx[3:2])
      FACE_TOP:   vert_next.vertex_shade = top_shade;
      FACE_LEFT:  vert_next.vertex_shade = shade_left;
      FACE_RIGHT: vert_next.vertex_shade = shade_right;
      default:    vert_next.vertex_shade = top_shade;
    endcase

    unique case (vidx)
      4'd0: begin
        vert_next.vertex_x = geo7.x_a;     vert_next.vertex_y = geo7.y_t0;
        vert_next.tex_u    = u_one;        vert_next.tex_v    = v_base;
      end
      4'd1: begin
        vert_next.vertex_x = geo7.x_nb;    vert_next.vertex_y = geo7.y_t1;
        vert_next.tex_u    = u_base;       vert_next.tex_v    = v_base;
      end
      4'd2: begin
        vert_next.vertex_x = geo7.x_na;    vert_next.vertex_y = geo7.y_t2;
        vert_next.tex_u    = u_base;       vert_next.tex_v    = v_one;
      end
      4'd3: begin
        vert_next.vertex_x = geo7.x_b;     vert_next.vertex_y = geo7.y_t3;
        vert_next.tex_u    = u_one;        vert_next.tex_v    = v_one;
      end
      4'd4: begin
        vert_next.vertex_x = geo7.x_mid;   vert_next.vertex_y = geo7.y_mid;
        vert_next.tex_u    = u_two;        vert_next.tex_v    = v_base;
      end
      4'd5: begin
        vert_next.vertex_x = geo7.x_left;  vert_next.vertex_y = geo7.y_left_top;
        vert_next.tex_u    = u_one;        vert_next.tex_v    = v_base;
      end
      4'd6: begin
        vert_next.vertex_x = geo7.x_left;  vert_next.vertex_y = geo7.y_left_bot;
        vert_next.tex_u    = u_one;        vert_next.tex_v    = v_one;
      end
      4'd7: begin
        vert_next.vertex_x = geo7.x_mid;   vert_next.vertex_y = geo7.y_mid_lo;
        vert_next.tex_u    = u_two;        vert_next.tex_v    = v_one;
      end
      4'd8: begin
        vert_next.vertex_x = geo7.x_right; vert_next.vertex_y = geo7.y_right_top;
        vert_next.tex_u    = u_two;        vert_next.tex_v    = v_base;
      end
      4'd9: begin
        vert_next.vertex_x = geo7.x_mid;   vert_next.vertex_y = geo7.y_mid;
        vert_next.tex_u    = u_one;        vert_next.tex_v    = v_base;
      end
      4'd10: begin
        vert_next.vertex_x = geo7.x_mid;   vert_next.vertex_y = geo7.y_mid_lo;
        vert_next.tex_u    = u_one;        vert_next.tex_v    = v_one;
      end
      4'd11: begin
        vert_next.vertex_x = geo7.x_right; vert_next.vertex_y = geo7.y_right_bot;
        vert_next.tex_u    = u_two;        vert_next.tex_v    = v_one;
      end
      default: begin
        vert_next.vertex_x = geo7.x_mid;   vert_next.vertex_y = geo7.y_mid;
        vert_next.tex_u    = u_base;       vert_next.tex_v    = v_base;
      end
    endcase
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (emit) out_data <= vert_next;
  end

  // ---------------------------------------------------------------------------
  // A cube's vertices leave back to back: no gap after a non-final vertex
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_vertex |=> out_valid)
    else $error("vertex stream broke inside a cube");

  // The vertex counter only runs while the last stage holds a cube
  assert property (@(posedge clk) disable iff (rst)
    vidx != 4'd0 |-> pipe_valid[NUM_STAGES])
    else $error("vertex counter active with empty final stage");

  assert property (@(posedge clk) disable iff (rst)
    vidx <= LAST_VERTEX_IDX)
    else $error("vertex counter out of range");

  // An empty first stage never pushes back on requests
  assert property (@(posedge clk) disable iff (rst)
    !pipe_valid[1] |-> !in_stall)
    else $error("request stalled with free input stage");

endmodule

FILE: tb/projected_cube_vertex_generator_core_test.sv
`timescale 1ns / 1ps

module projected_cube_vertex_generator_core_test;
  import pcvg_pkg::*;

  class cube_vertex_board;
    int unsigned failures;
    int unsigned vertex_count;
    vertex_t     expected_vertices[$];
    int          sine_q15[QUARTER_TURN + 1];
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [8:0]  size_reg;
    logic [31:0] top_rgba;
    logic [31:0] front_rgba;
    logic [31:0] left_rgba;
    logic [31:0] back_rgba;
    logic [31:0] right_rgba;

    function new();
      for (int a = 0; a <= QUARTER_TURN; a++) sine_q15[a] = taylor_sine(a);
      col_reg    = '0;
      row_reg    = '0;
      size_reg   = 9'd16;
      top_rgba   = '1;
      front_rgba = '1;
      left_rgba  = '1;
      back_rgba  = '1;
      right_rgba = '1;
    endfunction

    // Sine of a quarter-turn angle, Q1.15, by series to the x^13 term
    function int taylor_sine(int unsigned ang);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned d;
      longint          sum;
      x = (longint'(ang) * RAD_PER_DEG_Q30 + ((64'd1 << ANGLE_FRAC_BITS) >> 1))
          >> ANGLE_FRAC_BITS;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        d = longint'((2 * k) * (2 * k + 1));
        term = ((term * x2) >> 30) / d;
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum <= 0) return 0;
      sum = (sum + (longint'(1) <<< 14)) >>> 15;
      return (sum > 32768) ? 32768 : int'(sum);
    endfunction

    // Round half up from 31 fraction bits, then clamp
    function coord_t to_q14(longint g);
      longint q;
      q = (g + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (q > 32767) return coord_t'(32767);
      if (q < -32768) return coord_t'(-32768);
      return coord_t'(q);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        CFG_TILE_COLUMN: col_reg = d[7:0];
        CFG_TILE_ROW:    row_reg = d[7:0];
        CFG_TILE_SIZE:   size_reg = d[8:0];
        CFG_TOP_SHADE:   top_rgba = d;
        CFG_FRONT_SHADE: front_rgba = d;
        CFG_LEFT_SHADE:  left_rgba = d;
        CFG_BACK_SHADE:  back_rgba = d;
        CFG_RIGHT_SHADE: right_rgba = d;
        default: ;
      endcase
    endfunction

    function void note_request(angle_req_t r);
      int unsigned     yaw;
      int unsigned     pitch;
      int unsigned     rem;
      yaw_quad_t       quad;
      longint          tr, tc, sy, cy, sp, cp, diag_a, diag_b, h, mx, my, tu, tl;
      longint          px[VERTS_PER_CUBE];
      longint          py[VERTS_PER_CUBE];
      longint unsigned pu[VERTS_PER_CUBE];
      longint unsigned pv[VERTS_PER_CUBE];
      longint unsigned s, u0, v0;
      logic [31:0]     left_sel, right_sel;
      vertex_t         v;
      yaw = r.yaw_angle % FULL_TURN;
      quad = yaw_quad_t'(yaw / QUARTER_TURN);
      rem = yaw % QUARTER_TURN;
      pitch = (r.pitch_angle > QUARTER_TURN) ? QUARTER_TURN : r.pitch_angle;
      tr = sine_q15[rem];
      tc = sine_q15[QUARTER_TURN - rem];
      sp = sine_q15[pitch];
      cp = sine_q15[QUARTER_TURN - pitch];
      case (quad)
        YAW_Q0: begin
          sy = tr;  cy = tc;  left_sel = right_rgba; right_sel = front_rgba;
        end
        YAW_Q1: begin
          sy = tc;  cy = -tr; left_sel = back_rgba;  right_sel = right_rgba;
        end
        YAW_Q2: begin
          sy = -tr; cy = -tc; left_sel = left_rgba;  right_sel = back_rgba;
        end
        default: begin
          sy = -tc; cy = tr;  left_sel = front_rgba; right_sel = left_rgba;
        end
      endcase

      // top quad: rotated half diagonal, y foreshortened by pitch
      diag_a = cy - sy;
      diag_b = cy + sy;
      h = cp * 32768;
      px[0] = diag_a * 32768;  py[0] = diag_b * sp + h;
      px[1] = -diag_b * 32768; py[1] = diag_a * sp + h;
      px[2] = -diag_a * 32768; py[2] = -diag_b * sp + h;
      px[3] = diag_b * 32768;  py[3] = -diag_a * sp + h;

      // side quads hang from the near top corner, sheared by edge heights
      mx = (tr - tc) * 32768;
      my = h - (tc + tr) * sp;
      tu = 2 * tc * sp;
      tl = 2 * tr * sp;
      px[4] = mx;               py[4] = my;
      px[5] = mx - tr * 65536;  py[5] = my + tu;
      px[6] = mx - tr * 65536;  py[6] = my - cp * 65536 + tu;
      px[7] = mx;               py[7] = my - cp * 65536;
      px[8] = mx + tc * 65536;  py[8] = my + tl;
      px[9] = mx;               py[9] = my;
      px[10] = mx;              py[10] = my - cp * 65536;
      px[11] = mx + tc * 65536; py[11] = my - cp * 65536 + tl;

      s = size_reg;
      u0 = col_reg * s * 2;
      v0 = row_reg * s;
      pu[0] = u0 + s; pv[0] = v0;
      pu[1] = u0;     pv[1] = v0;
      pu[2] = u0;     pv[2] = v0 + s;
      pu[3] = u0 + s; pv[3] = v0 + s;
      for (int i = 4; i < VERTS_PER_CUBE; i += 4) begin
        pu[i] = u0 + 2 * s;     pv[i] = v0;
        pu[i + 1] = u0 + s;     pv[i + 1] = v0;
        pu[i + 2] = u0 + s;     pv[i + 2] = v0 + s;
        pu[i + 3] = u0 + 2 * s; pv[i + 3] = v0 + s;
      end

      for (int i = 0; i < VERTS_PER_CUBE; i++) begin
        v.vertex_x = to_q14(px[i]);
        v.vertex_y = to_q14(py[i]);
        v.tex_u = U_W'(pu[i]);
        v.tex_v = V_W'(pv[i]);
        if (i < 4) begin
          v.face_index = FACE_TOP;
          v.vertex_shade = top_rgba;
        end else if (i < 8) begin
          v.face_index = FACE_LEFT;
          v.vertex_shade = left_sel;
        end else begin
          v.face_index = FACE_RIGHT;
          v.vertex_shade = right_sel;
        end
        v.last_vertex = (i == VERTS_PER_CUBE - 1);
        expected_vertices.push_back(v);
      end
    endfunction

    task report(string what);
      failures++;
      $display("mismatch: %s", what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("vertex %0d %s: got %0h, want %0h", vertex_count, name, got, want));
    endtask

    task check_vertex(vertex_t got);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        report($sformatf("vertex %0d arrived with none expected", vertex_count));
        vertex_count++;
        return;
      end
      want = expected_vertices.pop_front();
      check_field("x", 32'(got.vertex_x), 32'(want.vertex_x));
      check_field("y", 32'(got.vertex_y), 32'(want.vertex_y));
      check_field("shade", got.vertex_shade, want.vertex_shade);
      check_field("u", 32'(got.tex_u), 32'(want.tex_u));
      check_field("v", 32'(got.tex_v), 32'(want.tex_v));
      check_field("face", 32'(got.face_index), 32'(want.face_index));
      check_field("last", 32'(got.last_vertex), 32'(want.last_vertex));
      vertex_count++;
    endtask
  endclass

  localparam int QUIET_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 12;
  localparam int NUM_PHASES       = 6;
  localparam int RANDOM_PER_PHASE = 56;
  localparam int NUM_DIRECTED     = 16;

  localparam int unsigned DIR_YAW [NUM_DIRECTED] = '{
    0, 0, 1440, 1439, 1441, 2880, 4320, 5759, 5760, 8191, 720, 2160, 3600, 5040, 4096, 1};
  localparam int unsigned DIR_PITCH [NUM_DIRECTED] = '{
    0, 1440, 0, 720, 720, 1440, 1, 1439, 0, 2047, 720, 1441, 1024, 360, 2047, 1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  angle_req_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  vertex_t     out_data;
  logic        cfg_wr_en = 1'b0;
  cfg_reg_t    cfg_index = CFG_TILE_COLUMN;
  logic [31:0] cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  cube_vertex_board board = new();

  projected_cube_vertex_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    logic take_req;
    logic take_vtx;
    take_req = !rst && in_valid && !in_stall;
    take_vtx = !rst && out_valid && !out_stall;
    if (take_req) board.note_request(in_data);
    if (take_vtx) board.check_vertex(out_data);
    if (take_req || take_vtx) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_request(angle_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let every pending vertex out, then let the pipeline settle
  task automatic wait_for_vertices();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_setting(int k);
    logic [31:0] val [8];
    cfg_reg_t    idx;
    foreach (val[i]) val[i] = $urandom;
    case (k)
      0: begin
        val[CFG_TILE_COLUMN] = '1;
        val[CFG_TILE_ROW] = '1;
        val[CFG_TILE_SIZE] = '1;
      end
      1: foreach (val[i]) val[i] = '0;
      2: begin
        val[CFG_TILE_COLUMN] = 32'd255;
        val[CFG_TILE_ROW] = 32'd255;
        val[CFG_TILE_SIZE] = 32'd256;
        val[CFG_TOP_SHADE] = '1;
      end
      3: val[CFG_TILE_SIZE] = 32'd1;
      4: val[CFG_TILE_SIZE] = $urandom_range(511);
      default: ;
    endcase
    idx = idx.first();
    for (int n = 0; n < idx.num(); n++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val[idx];
      @(posedge clk);
      board.set_reg(idx, val[idx]);
      idx = idx.next();
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic angle_req_t random_request();
    angle_req_t  r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) r.yaw_angle = YAW_W'($urandom_range(FULL_TURN - 1));
    else if (pick < 85)
      r.yaw_angle = YAW_W'(QUARTER_TURN * $urandom_range(4) + $urandom_range(2) - 1);
    else r.yaw_angle = YAW_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) r.pitch_angle = PITCH_W'($urandom_range(QUARTER_TURN));
    else if (pick < 85)
      r.pitch_angle = PITCH_W'($urandom_range(2 ** PITCH_W - 1, QUARTER_TURN + 1));
    else if (pick < 92) r.pitch_angle = PITCH_W'($urandom_range(1));
    else r.pitch_angle = PITCH_W'(QUARTER_TURN - $urandom_range(1));
    return r;
  endfunction

  initial begin
    angle_req_t req;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      req.yaw_angle = YAW_W'(DIR_YAW[i]);
      req.pitch_angle = PITCH_W'(DIR_PITCH[i]);
      send_request(req);
    end

    for (int k = 0; k < NUM_PHASES; k++) begin
      wait_for_vertices();
      program_setting(k);
      case (k % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      repeat (RANDOM_PER_PHASE) send_request(random_request());
    end
    wait_for_vertices();

    if (board.failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
design/pcvg_pkg.sv
design/projected_cube_vertex_generator_core.sv
tb/projected_cube_vertex_generator_core_test.sv
